### rtl/core/sprite_rle_decoder_defines.svh
// Assertion macros shared by the sprite run-length decoder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SPRITE_RLE_DECODER_DEFINES_SVH
`define SPRITE_RLE_DECODER_DEFINES_SVH

// Property that must hold at every rising edge outside of reset.
`define SRD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sprite_rle_decoder assertion failed in %m");

// A condition at one edge implies a property at the next edge.
`define SRD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("sprite_rle_decoder next-cycle assertion failed in %m");

`endif

### rtl/core/srd_pkg.sv
// Shared types and constants for the sprite run-length decoder.
// Depends on nothing; imported by every module of the decoder.
package srd_pkg;

   // Input item kinds, carried on req_tuser.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_CMD   = 2'd1;
   localparam logic [1:0] OP_PIXEL = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIRROR    = 8'd1;

   // Field widths and limits.
   localparam int unsigned CURSOR_W   = 11;
   localparam int unsigned ROW_W      = 10;
   localparam int unsigned COPY_W     = 8;
   localparam int unsigned SKIP_W     = 7;
   localparam int unsigned PIXEL_W    = 8;
   localparam int unsigned FIELD_LIMIT = 1024;
   localparam logic [CURSOR_W-1:0] CURSOR_MAX = 11'd2047;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] value;
   } req_item_type;

   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [ROW_W-1:0]   column;
      logic [PIXEL_W-1:0] pixel;
      logic               written;
      logic               stray;
   } rsp_item_type;

endpackage

### rtl/core/srd_in_stage.sv
// Input register of the sprite run-length decoder.
// Depends on srd_pkg for the input item type.
module srd_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  srd_pkg::req_item_type req_item,
   input  logic                 advance,
   output logic                 item_valid,
   output srd_pkg::req_item_type item
);
   import srd_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   // The slot takes a new item when it is empty or its item moves on.
   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### rtl/core/srd_core.sv
// Cursor, row and copy-count state with the per-item decode logic.
// Depends on srd_pkg for item types, operation codes and limits.
module srd_core #(
   parameter logic [9:0] LAST_ROW = 10'd1023
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  srd_pkg::req_item_type item,
   input  logic [10:0]           eff_width,
   input  logic                  mirror,
   output logic                  result_valid,
   output srd_pkg::rsp_item_type result
);
   import srd_pkg::*;

   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COPY_W-1:0]   pend_ff, pend_in;

   logic [CURSOR_W-1:0] base;
   logic [CURSOR_W:0]   skip_sum;
   logic [CURSOR_W-1:0] col_full;
   logic                visible;

   always_comb begin
      cursor_in    = cursor_ff;
      row_in       = row_ff;
      pend_in      = pend_ff;
      result_valid = 1'b0;

      base     = item.value[15] ? '0 : cursor_ff;
      skip_sum = {1'b0, base} + {{(CURSOR_W + 1 - SKIP_W){1'b0}}, item.value[14:8]};
      visible  = cursor_ff < eff_width;
      col_full = mirror ? (eff_width - 11'd1 - cursor_ff) : cursor_ff;

      result.row     = row_ff;
      result.column  = '0;
      result.pixel   = item.value[PIXEL_W-1:0];
      result.written = 1'b0;
      result.stray   = 1'b0;

      unique case (item.op)
         OP_START: begin
            cursor_in = '0;
            row_in    = '0;
            pend_in   = '0;
         end
         OP_CMD: begin
            if (item.value[15] && (row_ff < LAST_ROW)) begin
               row_in = row_ff + 10'd1;
            end
            cursor_in = skip_sum[CURSOR_W] ? CURSOR_MAX : skip_sum[CURSOR_W-1:0];
            pend_in   = item.value[COPY_W-1:0];
         end
         OP_PIXEL: begin
            result_valid = 1'b1;
            if (pend_ff == '0) begin
               result.stray = 1'b1;
            end else begin
               if (visible) begin
                  result.written = 1'b1;
                  result.column  = col_full[ROW_W-1:0];
               end
               if (cursor_ff != CURSOR_MAX) begin
                  cursor_in = cursor_ff + 11'd1;
               end
               pend_in = pend_ff - 8'd1;
            end
         end
         default: begin
            // Unused operation code: no result, no state change.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         row_ff    <= '0;
         pend_ff   <= '0;
      end else if (step) begin
         cursor_ff <= cursor_in;
         row_ff    <= row_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

### rtl/core/srd_out_stage.sv
// Result register of the sprite run-length decoder.
// Depends on srd_pkg for the result item type.
module srd_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  load_valid,
   input  srd_pkg::rsp_item_type load_item,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output srd_pkg::rsp_item_type rsp_item
);
   import srd_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // Free when empty or when the held result leaves this cycle.
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      if (load) begin
         valid_in = load_valid;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         item_ff <= load_item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

### rtl/core/sprite_rle_decoder.sv
// Top level of the sprite run-length decoder: ports, configuration registers.
// Depends on srd_pkg, srd_in_stage, srd_core, srd_out_stage and the defines header.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_tvalid/req_tready   tuser operation, tdata value
//   rsp_      out        rsp_tvalid/rsp_tready   tdata row/column/pixel, tuser flags
//   csr_      in         csr_valid/csr_ready     csr_index, csr_data
//
// Every item passes from its transfer on req_ to its result on rsp_ through the input
// register, then through the decode logic into the result register. One item is
// accepted per cycle while rsp_ is not stalled; the rate is set by the per-item update
// of the cursor, row and copy-count registers. A stall on rsp_ holds the result
// register and backs up into the input register, then into req_tready.
// Reset clears the decode state and loads row_width and mirror to their defaults.
`include "sprite_rle_decoder_defines.svh"

module sprite_rle_decoder #(
   parameter int unsigned MAX_WIDTH = 1024,
   parameter int unsigned MAX_ROWS  = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // Input item channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] value
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [9:0] row, [19:10] column, [27:20] pixel, zero fill
   output logic [1:0]  rsp_tuser,   // [0] written, [1] stray
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [10:0] csr_data
);
   import srd_pkg::*;

   // Effective clip width and last row follow from the size parameters.
   localparam int unsigned WIDTH_CAP = (MAX_WIDTH > FIELD_LIMIT) ? FIELD_LIMIT : MAX_WIDTH;
   localparam int unsigned ROW_CAP   = (MAX_ROWS > FIELD_LIMIT) ? FIELD_LIMIT : MAX_ROWS;
   localparam logic [10:0] WIDTH_CAP_W = 11'(WIDTH_CAP);
   localparam logic [9:0]  LAST_ROW    = 10'(ROW_CAP - 1);

   // The width register stores the already clamped width, so the decode
   // path sees min(row_width, MAX_WIDTH, 1024) without a compare of its own.
   logic [10:0] width_ff, width_in;
   logic        mirror_ff, mirror_in;

   logic         item_valid;
   req_item_type req_item;
   req_item_type item;
   logic         advance;
   logic         out_free;
   logic         result_valid;
   rsp_item_type result;
   rsp_item_type rsp_item;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      mirror_in = mirror_ff;
      if (csr_valid) begin
         if (csr_index == CSR_ROW_WIDTH) begin
            width_in = (csr_data > WIDTH_CAP_W) ? WIDTH_CAP_W : csr_data;
         end else if (csr_index == CSR_MIRROR) begin
            mirror_in = csr_data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_CAP_W;
         mirror_ff <= 1'b0;
      end else begin
         width_ff  <= width_in;
         mirror_ff <= mirror_in;
      end
   end

   assign req_item.op    = req_tuser;
   assign req_item.value = req_tdata;

   // An item moves through the decode logic when the result register can
   // take whatever it produces; items without a result move the same way.
   assign advance = item_valid && out_free;

   srd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   srd_core #(
      .LAST_ROW (LAST_ROW)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .item         (item),
      .eff_width    (width_ff),
      .mirror       (mirror_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   srd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (result_valid),
      .load_item  (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {4'd0, rsp_item.pixel, rsp_item.column, rsp_item.row};
   assign rsp_tuser = {rsp_item.stray, rsp_item.written};

   // A stray pixel is never placed, so its column reads zero.
   `SRD_ASSERT(a_stray_no_column, clock, reset,
      !(rsp_tvalid && rsp_tuser[1]) || (rsp_tdata[19:10] == 10'd0))
   // The row counter saturates at the last row.
   `SRD_ASSERT(a_row_in_range, clock, reset, !rsp_tvalid || (rsp_tdata[9:0] <= LAST_ROW))
   // A held input item stays in its register until the decode logic takes it.
   `SRD_ASSERT_NEXT(a_item_held, clock, reset, item_valid && !advance, item_valid)

endmodule
